>>> design/neighbor_node_table_defines.svh
// Assertion helpers for the neighbour node table.
`ifndef NEIGHBOR_NODE_TABLE_DEFINES_SVH
`define NEIGHBOR_NODE_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, idle in reset.
`define NNT_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, idle in reset.
`define NNT_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/nnt_pkg.sv
package nnt_pkg;

   localparam int ADDR_W     = 16;
   localparam int FC_W       = 24;
   localparam int PRIO_W     = 4;
   localparam int MTYPE_W    = 8;
   localparam int SUM_W      = 28;
   // widest slot index over the supported table sizes (up to 64 entries)
   localparam int MAX_IDX_W  = 6;

   localparam logic [1:0] OUT_UPDATED  = 2'd0;
   localparam logic [1:0] OUT_INSERTED = 2'd1;
   localparam logic [1:0] OUT_FULL     = 2'd2;
   localparam logic [1:0] OUT_IGNORED  = 2'd3;

   localparam logic [MTYPE_W-1:0] MSG_SKIP = 8'd1;

   typedef struct packed {
      logic [ADDR_W-1:0]  node_address;
      logic [FC_W-1:0]    forecast;
      logic [PRIO_W-1:0]  priority_req;
      logic [MTYPE_W-1:0] message_type;
   } req_type;

   typedef struct packed {
      logic [1:0]       outcome;
      logic [3:0]       slot;
      logic [4:0]       entry_count;
      logic [SUM_W-1:0] forecast_sum;
   } rsp_type;

   // search token that walks the row of cells
   typedef struct packed {
      logic                 valid;
      logic                 hit;
      logic [MAX_IDX_W-1:0] slot;
      logic [ADDR_W-1:0]    address;
      logic [FC_W-1:0]      old_forecast;
   } probe_type;

   // write broadcast from the controller to the row
   typedef struct packed {
      logic                 en;
      logic                 set_addr;
      logic [MAX_IDX_W-1:0] slot;
      logic [ADDR_W-1:0]    address;
      logic [FC_W-1:0]      forecast;
      logic [PRIO_W-1:0]    prio_level;
      logic                 skip;
   } wr_type;

endpackage

>>> design/neighbor_node_table.sv
// Neighbour node table. Each request beat carries one status message (node address,
// forecast, priority, message type) and yields exactly one response beat with the
// outcome, the slot touched, the entry count and the running sum of stored forecasts.
// Entries live in a row of ENTRIES cells; a search token enters cell 0 in the cycle
// after the request beat and moves one cell per cycle, so the first (lowest) matching
// slot claims it. After the token leaves the last cell it is held in a register; once
// the response register is free, the controller writes the chosen cell and loads the
// response register in the same cycle. One message is handled at a time: the next
// request beat is taken only once the response register is loaded, and it is taken
// while a finished response still waits for rsp_ready. A zero address walks the row
// like any other but changes nothing. The forecast sum is kept incrementally and
// wraps modulo 2^28; slot and entry_count carry the low 4 and 5 bits of the internal
// values. No clearing pass follows reset.
`include "neighbor_node_table_defines.svh"

module neighbor_node_table
   import nnt_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int CNT_W = $clog2(ENTRIES + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_FINISH} state_type;

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   probe_type         probe_in_ff, probe_in_in;
   probe_type         done_ff, done_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   wr_type            wr;
   logic              rsp_free;
   probe_type         chain [ENTRIES+1];
   logic [ENTRIES:0]  probe_live;

   // the token enters the row from the controller's launch register
   assign chain[0]      = probe_in_ff;
   assign probe_live[0] = probe_in_ff.valid;

   for (genvar k = 0; k < ENTRIES; k++) begin : g_row
      nnt_cell #(
         .ENTRIES (ENTRIES),
         .INDEX   (k)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .count      (count_ff),
         .probe_up   (chain[k]),
         .probe_down (chain[k+1]),
         .wr         (wr)
      );
      assign probe_live[k+1] = chain[k+1].valid;
   end

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      probe_in_in  = '0;
      done_in      = done_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      wr           = '0;

      unique case (state_ff)
         ST_IDLE: begin
            // launch the token on the request beat
            if (req_valid) begin
               req_in              = req_data;
               probe_in_in.valid   = 1'b1;
               probe_in_in.address = req_data.node_address;
               state_in            = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            // hold the token once it falls off the end of the row
            if (chain[ENTRIES].valid) begin
               done_in  = chain[ENTRIES];
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               wr.address    = req_ff.node_address;
               wr.forecast   = req_ff.forecast;
               wr.prio_level = req_ff.priority_req;
               rsp_data_in.slot = '0;
               priority if (req_ff.node_address == '0) begin
                  rsp_data_in.outcome = OUT_IGNORED;
               end else if (done_ff.hit) begin
                  // refresh the matched entry, swap its forecast in the sum
                  wr.en       = 1'b1;
                  wr.slot     = done_ff.slot;
                  wr.skip     = (req_ff.message_type == MSG_SKIP);
                  sum_in      = SUM_W'(sum_ff - SUM_W'(done_ff.old_forecast)
                                       + SUM_W'(req_ff.forecast));
                  rsp_data_in.outcome = OUT_UPDATED;
                  rsp_data_in.slot    = 4'(done_ff.slot);
               end else if (count_ff < CNT_W'(ENTRIES)) begin
                  // append in the next free slot
                  wr.en       = 1'b1;
                  wr.set_addr = 1'b1;
                  wr.slot     = MAX_IDX_W'(count_ff);
                  wr.skip     = 1'b0;
                  count_in    = CNT_W'(count_ff + 1'b1);
                  sum_in      = SUM_W'(sum_ff + SUM_W'(req_ff.forecast));
                  rsp_data_in.outcome = OUT_INSERTED;
                  rsp_data_in.slot    = 4'(count_ff);
               end else begin
                  rsp_data_in.outcome = OUT_FULL;
               end
               rsp_data_in.entry_count  = 5'(count_in);
               rsp_data_in.forecast_sum = sum_in;
               rsp_valid_in             = 1'b1;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         probe_in_ff  <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         probe_in_ff  <= probe_in_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff      <= req_in;
      done_ff     <= done_in;
      rsp_data_ff <= rsp_data_in;
   end

   // at most one token in flight anywhere in the row
   `NNT_ASSERT_IMP(a_single_probe, 1'b1, $onehot0(probe_live), "more than one probe in the row")
   // a live token only exists during the search
   `NNT_ASSERT_IMP(a_probe_in_search, |probe_live, state_ff == ST_SEARCH, "probe outside search")
   // the table never grows past its size
   `NNT_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= CNT_W'(ENTRIES), "entry count past table size")
   // every request beat launches a token
   `NNT_ASSERT_NXT(a_launch, req_valid && req_ready, probe_in_ff.valid, "request without probe")

endmodule

>>> design/nnt_cell.sv
module nnt_cell
   import nnt_pkg::*;
#(
   parameter int ENTRIES = 16,
   parameter int INDEX   = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [$clog2(ENTRIES+1)-1:0] count,
   input  probe_type                    probe_up,
   output probe_type                    probe_down,
   input  wr_type                       wr
);

   localparam int CNT_W = $clog2(ENTRIES + 1);

   logic [ADDR_W-1:0] addr_ff;
   logic [FC_W-1:0]   forecast_ff;
   logic [PRIO_W-1:0] prio_ff;
   logic              fresh_ff;
   logic              skip_ff;
   probe_type         probe_ff;
   probe_type         probe_in;
   logic              wr_here;

   assign wr_here = wr.en && (wr.slot == MAX_IDX_W'(INDEX));

   // take the token only if no earlier cell has claimed it
   always_comb begin
      probe_in = probe_up;
      if (probe_up.valid && !probe_up.hit && (CNT_W'(INDEX) < count) &&
          (addr_ff == probe_up.address)) begin
         probe_in.hit          = 1'b1;
         probe_in.slot         = MAX_IDX_W'(INDEX);
         probe_in.old_forecast = forecast_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_ff <= '0;
      end else begin
         probe_ff <= probe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_here) begin
         if (wr.set_addr) begin
            addr_ff <= wr.address;
         end
         forecast_ff <= wr.forecast;
         prio_ff     <= wr.prio_level;
         fresh_ff    <= 1'b1;
         skip_ff     <= wr.skip;
      end
   end

   assign probe_down = probe_ff;

endmodule

>>> dv/tb_neighbor_node_table.sv
`timescale 1ns / 1ps

module tb_neighbor_node_table;
   import nnt_pkg::*;

   localparam int TABLE_DEPTH  = 16;
   localparam int RANDOM_ITEMS = 1230;
   // Each message waits on the cell row, plus a random request gap and response stall on each
   // side; the limit leaves a wide margin for the roughly 1300 messages of the run.
   localparam int LIMIT_CYCLES = 200000;
   localparam int REPORT_LIMIT = 10;

   // ------------------------------------------------------------------
   // Scoreboard: mirrors the neighbour table and queues one expected
   // response per accepted request beat.
   // ------------------------------------------------------------------
   class nnt_scoreboard;
      logic [ADDR_W-1:0] node_tab   [TABLE_DEPTH];
      logic [FC_W-1:0]   fcast_tab  [TABLE_DEPTH];
      logic [PRIO_W-1:0] prio_tab   [TABLE_DEPTH];
      bit                fresh_tab  [TABLE_DEPTH];
      bit                skip_tab   [TABLE_DEPTH];
      int unsigned       nodes_held;
      logic [SUM_W-1:0]  fcast_total;
      rsp_type           expected_rsp_q [$];
      int unsigned       mismatches;
      int unsigned       rsp_seen;
      int unsigned       outcome_tally [4];

      // Work out the response to one accepted message and queue it.
      function void note_message(req_type m);
         rsp_type exp_rsp;
         int      hit;
         exp_rsp = '0;
         hit     = -1;
         if (m.node_address == '0) begin
            // ignored message: table and sum are reported as they stand
            exp_rsp.outcome = OUT_IGNORED;
         end else begin
            // lowest matching slot wins
            for (int k = 0; k < nodes_held; k++) begin
               if (hit < 0 && node_tab[k] == m.node_address) hit = k;
            end
            if (hit >= 0) begin
               fresh_tab[hit] = 1'b1;
               fcast_tab[hit] = m.forecast;
               prio_tab[hit]  = m.priority_req;
               skip_tab[hit]  = (m.message_type == MSG_SKIP);
               exp_rsp.outcome = OUT_UPDATED;
               exp_rsp.slot    = hit[3:0];
            end else if (nodes_held < TABLE_DEPTH) begin
               node_tab[nodes_held]  = m.node_address;
               fcast_tab[nodes_held] = m.forecast;
               prio_tab[nodes_held]  = m.priority_req;
               fresh_tab[nodes_held] = 1'b1;
               skip_tab[nodes_held]  = 1'b0;
               exp_rsp.outcome = OUT_INSERTED;
               exp_rsp.slot    = nodes_held[3:0];
               nodes_held++;
            end else begin
               exp_rsp.outcome = OUT_FULL;
            end
            fcast_total = '0;
            for (int k = 0; k < nodes_held; k++) fcast_total = fcast_total + fcast_tab[k];
         end
         exp_rsp.entry_count  = nodes_held[4:0];
         exp_rsp.forecast_sum = fcast_total;
         expected_rsp_q.push_back(exp_rsp);
      endfunction

      // Compare one response beat with the oldest expectation.
      function void check_response(rsp_type got);
         rsp_type exp_rsp;
         rsp_seen++;
         if (expected_rsp_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("Unexpected response %0d: outcome %0d slot %0d count %0d sum %0d",
                        rsp_seen, got.outcome, got.slot, got.entry_count, got.forecast_sum);
            return;
         end
         exp_rsp = expected_rsp_q.pop_front();
         outcome_tally[exp_rsp.outcome]++;
         if (got.outcome != exp_rsp.outcome || got.slot != exp_rsp.slot ||
             got.entry_count != exp_rsp.entry_count ||
             got.forecast_sum != exp_rsp.forecast_sum) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("Mismatch on response %0d: expected outcome %0d slot %0d count %0d sum %0d",
                        rsp_seen, exp_rsp.outcome, exp_rsp.slot, exp_rsp.entry_count,
                        exp_rsp.forecast_sum);
               $display("   got outcome %0d slot %0d count %0d sum %0d",
                        got.outcome, got.slot, got.entry_count, got.forecast_sum);
            end
         end
      endfunction

      function int unsigned outstanding();
         return expected_rsp_q.size();
      endfunction

      function new();
         nodes_held  = 0;
         fcast_total = '0;
         mismatches  = 0;
         rsp_seen    = 0;
         foreach (outcome_tally[i]) outcome_tally[i] = 0;
      endfunction
   endclass

   // ------------------------------------------------------------------
   // Clock, reset and block under test
   // ------------------------------------------------------------------
   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   always #2 clock = ~clock;

   neighbor_node_table #(
      .ENTRIES(TABLE_DEPTH)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   nnt_scoreboard sb = new();

   // When set, both sides run flat out: no request gaps, no response stalls.
   bit              no_idle = 1'b0;
   int unsigned     cycle_count = 0;
   int unsigned     ready_hold = 0;
   int unsigned     rsp_stall;
   logic [ADDR_W-1:0] known_nodes [$];

   // Give up if the run hangs: the handshake never completes or responses stop.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles with %0d responses outstanding",
                  cycle_count, sb.outstanding());
         $display("Mismatches found");
         $finish;
      end
   end

   // Response side: check every accepted beat, then drop ready for a random stall,
   // possibly none, before taking the next one.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         ready_hold <= 0;
      end else if (rsp_ready) begin
         if (rsp_valid) begin
            sb.check_response(rsp_data);
            rsp_stall = no_idle ? 0 : $urandom_range(0, 3);
            if (rsp_stall != 0) begin
               rsp_ready  <= 1'b0;
               ready_hold <= rsp_stall - 1;
            end
         end
      end else if (ready_hold == 0) begin
         rsp_ready <= 1'b1;
      end else begin
         ready_hold <= ready_hold - 1;
      end
   end

   // Request side: idle for a random gap, then hold the beat until the block
   // takes it. Valid stays high straight into the next beat when the gap is
   // zero, so it is never dropped and raised within one time step.
   task automatic send_message(input logic [ADDR_W-1:0]  addr,
                               input logic [FC_W-1:0]    fcast,
                               input logic [PRIO_W-1:0]  prio,
                               input logic [MTYPE_W-1:0] mtype);
      req_type     msg;
      int unsigned gap;
      msg.node_address = addr;
      msg.forecast     = fcast;
      msg.priority_req = prio;
      msg.message_type = mtype;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= msg;
      do @(posedge clock); while (!req_ready);
      sb.note_message(msg);
   endtask

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      logic [ADDR_W-1:0]  addr;
      logic [FC_W-1:0]    fcast;
      logic [MTYPE_W-1:0] mtype;
      int unsigned        pick;
      int unsigned        item_idx;
      int unsigned        live_sent;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: empty table, inserts at both address extremes, updates
      // with and without the skip type, ignored messages, a fill to capacity
      // with the largest forecasts, then drops once the table is full.
      send_message('0, '0, '0, '0);
      send_message(16'h0001, '0, 4'd0, MSG_SKIP);
      send_message(16'hFFFF, '1, 4'd15, 8'hFF);
      send_message(16'h0001, '1, 4'd9, MSG_SKIP);
      send_message(16'hFFFF, '0, 4'd0, 8'h00);
      send_message(16'h0001, '1, 4'd15, 8'hFF);
      send_message('0, '1, 4'd15, MSG_SKIP);
      known_nodes.push_back(16'h0001);
      known_nodes.push_back(16'hFFFF);
      for (int k = 1; k <= TABLE_DEPTH - 2; k++) begin
         addr = 16'(16'h1000 * k + 16'h00AC);
         known_nodes.push_back(addr);
         send_message(addr, '1, k[3:0], 8'h02);
      end
      // refreshing 16'hFFFF with the largest forecast leaves it in every slot: the sum hits its ceiling
      send_message(16'hFFFF, '1, 4'd3, MSG_SKIP);
      send_message(16'h1234, 24'h5A5A5A, 4'd7, 8'h00);
      send_message(16'h8000, '1, 4'd0, MSG_SKIP);
      send_message('0, '0, 4'd0, 8'h00);

      // Random part: mostly known nodes (updates across every slot), some
      // strangers (dropped while full) and a little zero-address noise.
      // Every 250 beats, run a flat-out stretch with no gaps or stalls.
      item_idx  = 0;
      live_sent = 0;
      while (live_sent < RANDOM_ITEMS) begin
         no_idle = ((item_idx % 250) < 40);
         pick = $urandom_range(0, 99);
         if (pick < 8)
            addr = '0;
         else if (pick < 72)
            addr = known_nodes[$urandom_range(0, known_nodes.size() - 1)];
         else
            addr = 16'($urandom_range(1, 16'hFFFF));
         pick = $urandom_range(0, 99);
         if (pick < 10)
            fcast = '0;
         else if (pick < 25)
            fcast = '1;
         else
            fcast = 24'($urandom);
         pick = $urandom_range(0, 99);
         if (pick < 40)
            mtype = MSG_SKIP;
         else if (pick < 50)
            mtype = '0;
         else
            mtype = 8'($urandom_range(0, 255));
         send_message(addr, fcast, 4'($urandom_range(0, 15)), mtype);
         live_sent++;
         item_idx++;
      end
      req_valid <= 1'b0;
      no_idle   = 1'b0;

      // Drain: wait for every expected response, then allow one more message
      // time for anything stray to show up.
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (TABLE_DEPTH + 8) @(posedge clock);

      $display("Checked %0d responses: %0d updates, %0d inserts, %0d dropped on a full table,",
               sb.rsp_seen, sb.outcome_tally[OUT_UPDATED], sb.outcome_tally[OUT_INSERTED],
               sb.outcome_tally[OUT_FULL]);
      $display("%0d ignored zero-address messages; %0d response errors",
               sb.outcome_tally[OUT_IGNORED], sb.mismatches);
      if (sb.mismatches == 0 && sb.outstanding() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
